// ===== hdl/pbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfe_pkg
// Shared types and codes for the packed bit field extractor.
// ----------------------------------------------------------------------------
package pbfe_pkg;

  // request codes
  localparam logic [1:0] REQ_WR_REC  = 2'd0;
  localparam logic [1:0] REQ_WR_TBL  = 2'd1;
  localparam logic [1:0] REQ_EXTRACT = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REC_ERR = 2'd1;
  localparam logic [1:0] STS_ESC_ERR = 2'd2;

  localparam int unsigned RD_BYTES = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_SHIFT,
    S_CHECK,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RS_ZERO,
    RS_REC_ERR,
    RS_ESC_ERR,
    RS_RAW,
    RS_TBL
  } res_sel_t;

  typedef struct packed {
    logic       capture;
    logic       wr_rec;
    logic       wr_tbl;
    logic       rd_en;
    logic [2:0] rd_ix;
    logic       val_ld;
    logic       res_ld;
    res_sel_t   res_sel;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       wr_rec_oob;
    logic       wr_tbl_oob;
    logic       range_err;
    logic       esc_need;
    logic       esc_oob;
  } sts_t;

endpackage

// ===== hdl/packed_bit_field_extractor.sv =====
// ----------------------------------------------------------------------------
// packed_bit_field_extractor
// Bit field extraction from a packed record with escape table lookup.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  req_type addr wdata bit_offset
//                                          field_len escape_max use_escape
// out_     output     out_valid/out_stall  field_value escaped status
//
// writes, no-ops and fields beyond the record go from dispatch straight to the result state
// extracts: dispatch, five serial reads of the single-port byte memory, shift, check
//   and result, with or without an escape lookup, which is folded into the check state
// reset clears control only; record and table hold nothing until written
// a stalled result waits in the output register while the next transaction
//   is accepted and processed up to its result
// ----------------------------------------------------------------------------
module packed_bit_field_extractor
  import pbfe_pkg::*;
#(
  parameter int RECORD_BYTES = 64,
  parameter int ESCAPE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_addr,
  input  logic [31:0] in_wdata,
  input  logic [8:0]  in_bit_offset,
  input  logic [5:0]  in_field_len,
  input  logic [30:0] in_escape_max,
  input  logic        in_use_escape,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_field_value,
  output logic        out_escaped,
  output logic [1:0]  out_status
);

  cmd_t cmd;
  sts_t sts;

  pbfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbfe_dp #(
    .RECORD_BYTES (RECORD_BYTES),
    .ESCAPE_DEPTH (ESCAPE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_addr         (in_addr),
    .in_wdata        (in_wdata),
    .in_bit_offset   (in_bit_offset),
    .in_field_len    (in_field_len),
    .in_escape_max   (in_escape_max),
    .in_use_escape   (in_use_escape),
    .out_field_value (out_field_value),
    .out_escaped     (out_escaped),
    .out_status      (out_status)
  );

endmodule

// ===== hdl/pbfe_dp.sv =====
// ----------------------------------------------------------------------------
// pbfe_dp
// Datapath: request registers, record byte memory, escape table memory,
// bit alignment, escape compare and result registers.
// ----------------------------------------------------------------------------
module pbfe_dp
  import pbfe_pkg::*;
#(
  parameter int RECORD_BYTES = 64,
  parameter int ESCAPE_DEPTH = 256
) (
  input  logic        clk,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_addr,
  input  logic [31:0] in_wdata,
  input  logic [8:0]  in_bit_offset,
  input  logic [5:0]  in_field_len,
  input  logic [30:0] in_escape_max,
  input  logic        in_use_escape,
  output logic [31:0] out_field_value,
  output logic        out_escaped,
  output logic [1:0]  out_status
);

  localparam int RB_AW = $clog2(RECORD_BYTES);
  localparam int TW = (ESCAPE_DEPTH > 1) ? $clog2(ESCAPE_DEPTH) : 1;
  localparam logic [11:0] REC_BITS = 12'(8 * RECORD_BYTES);
  localparam logic [8:0] REC_LIM = 9'(RECORD_BYTES);
  localparam logic [31:0] TBL_LIM = 32'(ESCAPE_DEPTH);

  logic [7:0]  rec_mem [RECORD_BYTES];
  logic [31:0] tbl_mem [ESCAPE_DEPTH];

  logic [1:0]  req_r;
  logic [7:0]  addr_r;
  logic [31:0] wdata_r;
  logic [8:0]  off_r;
  logic [5:0]  len_r;
  logic [30:0] emax_r;
  logic        use_esc_r;
  logic [39:0] acc_r;
  logic [31:0] value_r;
  logic [31:0] res_value_r;
  logic        res_esc_r;
  logic [1:0]  res_status_r;
  logic [31:0] out_value_r;
  logic        out_esc_r;
  logic [1:0]  out_status_r;

  logic [8:0]  rd_sum;
  logic        rd_ok;
  logic        wr_rec_ok;
  logic [31:0] tbl_wr_ix;
  logic        wr_tbl_ok;
  logic [39:0] aligned;
  logic [5:0]  shift_amt;
  logic [31:0] extracted;
  logic [31:0] esc_ix;
  logic [11:0] field_end;

  always_comb begin
    rd_sum    = {3'b000, off_r[8:3]} + {6'b000000, cmd.rd_ix};
    rd_ok     = rd_sum < REC_LIM;
    wr_rec_ok = {1'b0, addr_r} < REC_LIM;
    tbl_wr_ix = {24'h000000, addr_r};
    wr_tbl_ok = tbl_wr_ix < TBL_LIM;
    aligned   = acc_r << off_r[2:0];
    shift_amt = 6'd32 - len_r;
    extracted = aligned[39:8] >> shift_amt;
    // value - (max + 1) == value + ~max
    esc_ix    = value_r + ~{1'b0, emax_r};
    field_end = {3'b000, off_r} + {6'b000000, len_r};
  end

  always_comb begin
    sts.req        = req_r;
    sts.wr_rec_oob = !wr_rec_ok;
    sts.wr_tbl_oob = !wr_tbl_ok;
    sts.range_err  = field_end > REC_BITS;
    sts.esc_need   = use_esc_r && !value_r[31] && (value_r[30:0] > emax_r);
    sts.esc_oob    = esc_ix >= TBL_LIM;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= in_req_type;
      addr_r    <= in_addr;
      wdata_r   <= in_wdata;
      off_r     <= in_bit_offset;
      len_r     <= (in_field_len > 6'd32) ? 6'd32 : in_field_len;
      emax_r    <= in_escape_max;
      use_esc_r <= in_use_escape;
    end
    if (cmd.val_ld) begin
      value_r <= extracted;
    end
  end

  // record byte memory, one access a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_rec && wr_rec_ok) begin
      rec_mem[addr_r[RB_AW-1:0]] <= wdata_r[7:0];
    end
    if (cmd.rd_en) begin
      acc_r <= {acc_r[31:0], rd_ok ? rec_mem[rd_sum[RB_AW-1:0]] : 8'h00};
    end
  end

  // escape table memory and result register
  always_ff @(posedge clk) begin
    if (cmd.wr_tbl && wr_tbl_ok) begin
      tbl_mem[tbl_wr_ix[TW-1:0]] <= wdata_r;
    end
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RS_REC_ERR: begin
          res_value_r  <= 32'h0;
          res_esc_r    <= 1'b0;
          res_status_r <= STS_REC_ERR;
        end
        RS_ESC_ERR: begin
          res_value_r  <= 32'h0;
          res_esc_r    <= 1'b0;
          res_status_r <= STS_ESC_ERR;
        end
        RS_RAW: begin
          res_value_r  <= value_r;
          res_esc_r    <= 1'b0;
          res_status_r <= STS_OK;
        end
        RS_TBL: begin
          res_value_r  <= tbl_mem[esc_ix[TW-1:0]];
          res_esc_r    <= 1'b1;
          res_status_r <= STS_OK;
        end
        default: begin
          res_value_r  <= 32'h0;
          res_esc_r    <= 1'b0;
          res_status_r <= STS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_value_r  <= res_value_r;
      out_esc_r    <= res_esc_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_field_value = out_value_r;
  assign out_escaped     = out_esc_r;
  assign out_status      = out_status_r;

endmodule

// ===== hdl/pbfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbfe_ctrl
// Controller: sequences request dispatch, byte reads, escape lookup and
// the output handshake.
// ----------------------------------------------------------------------------
module pbfe_ctrl
  import pbfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] LAST_RD = 3'(RD_BYTES - 1);

  state_t     state_r;
  state_t     state_nxt;
  logic [2:0] byte_cnt_r;
  logic [2:0] byte_cnt_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.req == REQ_EXTRACT && !sts.range_err) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_READ: begin
        if (byte_cnt_r == LAST_RD) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = RS_ZERO;
    cmd.rd_ix    = byte_cnt_r;
    in_stall     = 1'b1;
    byte_cnt_nxt = 3'd0;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        case (sts.req)
          REQ_WR_REC: begin
            cmd.wr_rec  = 1'b1;
            cmd.res_ld  = 1'b1;
            cmd.res_sel = sts.wr_rec_oob ? RS_REC_ERR : RS_ZERO;
          end
          REQ_WR_TBL: begin
            cmd.wr_tbl  = 1'b1;
            cmd.res_ld  = 1'b1;
            cmd.res_sel = sts.wr_tbl_oob ? RS_ESC_ERR : RS_ZERO;
          end
          REQ_EXTRACT: begin
            cmd.res_ld  = sts.range_err;
            cmd.res_sel = RS_REC_ERR;
          end
          default: begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RS_ZERO;
          end
        endcase
      end
      S_READ: begin
        cmd.rd_en    = 1'b1;
        byte_cnt_nxt = byte_cnt_r + 3'd1;
      end
      S_SHIFT: begin
        cmd.val_ld = 1'b1;
      end
      S_CHECK: begin
        cmd.res_ld = 1'b1;
        if (!sts.esc_need) begin
          cmd.res_sel = RS_RAW;
        end else if (sts.esc_oob) begin
          cmd.res_sel = RS_ESC_ERR;
        end else begin
          cmd.res_sel = RS_TBL;
        end
      end
      S_RESULT: begin
        cmd.out_ld = out_free;
      end
      default: begin
        cmd.capture = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      byte_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !(out_valid_r && out_stall))
    else $error("held transaction overwritten");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_read_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && byte_cnt_r == LAST_RD) |=> (state_r == S_SHIFT))
    else $error("byte read sequence overran");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid_r)
    else $error("result load lost");
`endif

endmodule
